>>> rtl/btcc_pkg.sv
// ----------------------------------------------------------------------------
// btcc_pkg: shared types and constants of the bound table coverage checker.
// Holds operation codes, config bit positions and the slot count default.
// ----------------------------------------------------------------------------
package btcc_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int ADDR_W        = 64;
    localparam int CFG_W         = 4;
    localparam int SEL_W         = 4;
    localparam int CFG_VALID_BIT = 3;

    typedef enum logic [2:0] {
        OP_ALLOC    = 3'd0,
        OP_FREE     = 3'd1,
        OP_FREE_ALL = 3'd2,
        OP_CHECK    = 3'd3,
        OP_READ     = 3'd4
    } op_t;

    // Request to the bound memory: one read and one write.
    typedef struct packed {
        logic              rd_en;
        logic [SEL_W-1:0]  rd_addr;
        logic              wr_en;
        logic [SEL_W-1:0]  wr_addr;
        logic [ADDR_W-1:0] wr_lo;
        logic [ADDR_W-1:0] wr_hi;
    } mem_req_t;

endpackage

>>> rtl/bound_table_coverage_checker_unit.sv
// ----------------------------------------------------------------------------
// bound_table_coverage_checker_unit: top level.
// Bound table with alloc, free, free-all, read and range coverage check.
//
//   channel   direction  handshake          payload
//   request   in         start && !busy     kind perm_bits range_lo range_hi slot_sel
//   result    out        done (one cycle)   ok slot_out covered slot_cfg
//
// Alloc, free, free-all and read pass from idle through the exec and done states.
// A check walks the bound memory one slot per cycle in passes of SLOTS reads,
// each closed by the last state, which folds in the last slot, until a pass
// changes nothing.
// Reset clears every config at once; bounds need no clearing.
// busy is high from an accepted request until the cycle its result is shown.
// ----------------------------------------------------------------------------
module bound_table_coverage_checker_unit #(
    parameter int SLOTS = btcc_pkg::SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    kind,
    input  logic [3:0]                    perm_bits,
    input  logic [btcc_pkg::ADDR_W-1:0]   range_lo,
    input  logic [btcc_pkg::ADDR_W-1:0]   range_hi,
    input  logic [btcc_pkg::SEL_W-1:0]    slot_sel,
    output logic                          done,
    output logic                          ok,
    output logic [3:0]                    slot_out,
    output logic                          covered,
    output logic [3:0]                    slot_cfg
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [btcc_pkg::ADDR_W-1:0] ADDR_MAX = '1;

    typedef enum logic [2:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_LAST, ST_DONE} state_t;

    state_t                          state_reg;
    logic [2:0]                      kind_reg;
    logic [3:0]                      perm_reg;
    logic [btcc_pkg::ADDR_W-1:0]     lo_reg, hi_reg, end_reg;
    logic [btcc_pkg::SEL_W-1:0]      sel_reg;
    logic [btcc_pkg::CFG_W-1:0]      cfg_reg [SLOTS];
    logic [IW-1:0]                   idx_reg, cmp_idx_reg;
    logic                            cmp_vld_reg, changed_reg;
    logic [btcc_pkg::CFG_W-1:0]      cfg_next [SLOTS];
    logic [btcc_pkg::ADDR_W-1:0]     end_next;
    logic                            changed_next;

    btcc_pkg::mem_req_t              req;
    logic [btcc_pkg::ADDR_W-1:0]     rd_lo, rd_hi;

    btcc_bound_mem #(.SLOTS(SLOTS)) u_mem (
        .clk   (clk),
        .req   (req),
        .rd_lo (rd_lo),
        .rd_hi (rd_hi)
    );

    // Lowest free slot for alloc.
    logic              found;
    logic [IW-1:0]     free_idx;
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!cfg_reg[i][btcc_pkg::CFG_VALID_BIT])
            begin
                found    = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    logic sel_in_range;
    assign sel_in_range = 32'(sel_reg) < SLOTS;

    logic [btcc_pkg::ADDR_W-1:0] up_al;
    assign up_al = (hi_reg > ADDR_MAX - 64'd7) ? ADDR_MAX
                 : ((hi_reg + 64'd7) & ~64'd7);

    always_comb
    begin
        req          = '0;
        req.rd_en    = (state_reg == ST_SCAN);
        req.rd_addr  = btcc_pkg::SEL_W'(idx_reg);
        req.wr_en    = (state_reg == ST_EXEC) && (kind_reg == btcc_pkg::OP_ALLOC) && found;
        req.wr_addr  = btcc_pkg::SEL_W'(free_idx);
        req.wr_lo    = lo_reg & ~64'd7;
        req.wr_hi    = up_al;
    end

    // Chain step on the entry read last cycle.
    logic [btcc_pkg::CFG_W-1:0] cc;
    logic elig, reach, join_e;
    always_comb
    begin
        cc     = cfg_reg[cmp_idx_reg];
        elig   = cc[btcc_pkg::CFG_VALID_BIT] && ((cc[2:0] & perm_reg[2:0]) != 3'd0);
        reach  = (end_reg == ADDR_MAX) || (rd_lo <= end_reg + 64'd1);
        join_e = cmp_vld_reg && elig && reach && (rd_hi > end_reg);
        end_next     = join_e ? rd_hi : end_reg;
        changed_next = changed_reg || join_e;
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
            cfg_next[i] = cfg_reg[i];
        if (state_reg == ST_EXEC)
        begin
            unique case (kind_reg)
                btcc_pkg::OP_ALLOC:
                    if (found)
                        cfg_next[free_idx] = perm_reg | 4'b1000;
                btcc_pkg::OP_FREE:
                    if (sel_in_range)
                        cfg_next[sel_reg[IW-1:0]][btcc_pkg::CFG_VALID_BIT] = 1'b0;
                btcc_pkg::OP_FREE_ALL:
                    for (int i = 0; i < SLOTS; i++)
                        cfg_next[i] = '0;
                default: ;
            endcase
        end
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done        <= 1'b0;
            cmp_vld_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
                cfg_reg[i] <= '0;
        end
        else
        begin
            done <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
                cfg_reg[i] <= cfg_next[i];
            unique case (state_reg)
                ST_IDLE:
                    if (start)
                    begin
                        kind_reg  <= kind;
                        perm_reg  <= perm_bits;
                        lo_reg    <= range_lo;
                        hi_reg    <= range_hi;
                        sel_reg   <= slot_sel;
                        end_reg   <= range_lo;
                        state_reg <= ST_EXEC;
                    end
                ST_EXEC:
                begin
                    ok       <= 1'b0;
                    slot_out <= '0;
                    covered  <= 1'b0;
                    slot_cfg <= '0;
                    idx_reg  <= '0;
                    changed_reg <= 1'b0;
                    state_reg <= ST_DONE;
                    unique case (kind_reg)
                        btcc_pkg::OP_ALLOC:
                        begin
                            ok       <= found;
                            slot_out <= found ? 4'(free_idx) : 4'd0;
                        end
                        btcc_pkg::OP_FREE:     ok <= sel_in_range;
                        btcc_pkg::OP_FREE_ALL: ok <= 1'b1;
                        btcc_pkg::OP_CHECK:    state_reg <= ST_SCAN;
                        btcc_pkg::OP_READ:
                        begin
                            ok       <= sel_in_range;
                            slot_cfg <= sel_in_range ? cfg_reg[sel_reg[IW-1:0]] : 4'd0;
                        end
                        default: ;
                    endcase
                end
                ST_SCAN:
                begin
                    end_reg     <= end_next;
                    changed_reg <= changed_next;
                    cmp_vld_reg <= 1'b1;
                    cmp_idx_reg <= idx_reg;
                    if (32'(idx_reg) == SLOTS - 1)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_LAST;
                    end
                    else
                        idx_reg <= idx_reg + IW'(1);
                end
                ST_LAST:
                begin
                    // Fold in the last slot of the pass, then decide on another pass.
                    cmp_vld_reg <= 1'b0;
                    end_reg     <= end_next;
                    changed_reg <= 1'b0;
                    if (changed_next)
                        state_reg <= ST_SCAN;
                    else
                    begin
                        ok        <= 1'b1;
                        covered   <= hi_reg <= end_next;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    done      <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == ST_IDLE) else $error("result outside idle");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result held for two cycles");
    a_cov_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && covered) |-> ok) else $error("covered without ok");
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> state_reg == ST_EXEC) else $error("request lost");

endmodule

>>> rtl/btcc_bound_mem.sv
// ----------------------------------------------------------------------------
// btcc_bound_mem: bound storage.
// Synchronous memory of lower and upper addresses, one read with a registered
// result and one write per cycle.
// ----------------------------------------------------------------------------
module btcc_bound_mem #(
    parameter int SLOTS = btcc_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  btcc_pkg::mem_req_t           req,
    output logic [btcc_pkg::ADDR_W-1:0]  rd_lo,
    output logic [btcc_pkg::ADDR_W-1:0]  rd_hi
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [btcc_pkg::ADDR_W-1:0] mem_lo [SLOTS];
    logic [btcc_pkg::ADDR_W-1:0] mem_hi [SLOTS];

    // Addresses from the control logic always stay below SLOTS.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_lo[req.wr_addr[IW-1:0]] <= req.wr_lo;
            mem_hi[req.wr_addr[IW-1:0]] <= req.wr_hi;
        end
        if (req.rd_en)
        begin
            rd_lo <= mem_lo[req.rd_addr[IW-1:0]];
            rd_hi <= mem_hi[req.rd_addr[IW-1:0]];
        end
    end

endmodule

>>> verif/tb_bound_table_coverage_checker_unit.sv
// ----------------------------------------------------------------------------
// Bound table coverage checker testbench.
// Drives table requests (alloc, free, free-all, check, read and unused kinds)
// through the start/busy handshake, predicts each result from a local copy of
// the bound table and compares every done strobe with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_bound_table_coverage_checker_unit;

    localparam int NSLOT = 16;
    localparam logic [63:0] ADDR_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic       ok;
        logic [3:0] slot_out;
        logic       covered;
        logic [3:0] slot_cfg;
    } answer_t;

    class bound_scoreboard;
        logic [3:0]  cfg_tab[NSLOT];
        logic [63:0] lo_tab[NSLOT];
        logic [63:0] hi_tab[NSLOT];
        answer_t     pending[$];
        int          errors;

        function new();
            errors = 0;
            foreach (cfg_tab[i])
            begin
                cfg_tab[i] = '0;
                lo_tab[i] = '0;
                hi_tab[i] = '0;
            end
        endfunction

        function logic reaches(logic [63:0] lo, logic [63:0] hi, logic [3:0] mask);
            logic [63:0] reach_end;
            logic changed;
            reach_end = lo;
            for (int p = 0; p < NSLOT; p++)
            begin
                changed = 1'b0;
                for (int i = 0; i < NSLOT; i++)
                begin
                    if (cfg_tab[i][btcc_pkg::CFG_VALID_BIT]
                        && (cfg_tab[i] & mask & 4'h7) != 0)
                    begin
                        if ((reach_end == ADDR_MAX || lo_tab[i] <= reach_end + 64'd1)
                            && hi_tab[i] > reach_end)
                        begin
                            reach_end = hi_tab[i];
                            changed = 1'b1;
                        end
                    end
                end
                if (!changed)
                    break;
            end
            return hi <= reach_end;
        endfunction

        function void note_request(logic [2:0] k, logic [3:0] pb, logic [63:0] lo,
                                   logic [63:0] hi, logic [3:0] sel);
            answer_t a;
            a = '{1'b0, 4'd0, 1'b0, 4'd0};
            case (k)
                btcc_pkg::OP_ALLOC:
                begin
                    for (int i = 0; i < NSLOT; i++)
                    begin
                        if (!cfg_tab[i][btcc_pkg::CFG_VALID_BIT])
                        begin
                            lo_tab[i] = {lo[63:3], 3'b000};
                            hi_tab[i] = (hi > ADDR_MAX - 64'd7) ? ADDR_MAX
                                      : ((hi + 64'd7) & ~64'd7);
                            cfg_tab[i] = pb | 4'h8;
                            a.ok = 1'b1;
                            a.slot_out = i[3:0];
                            break;
                        end
                    end
                end
                btcc_pkg::OP_FREE:
                begin
                    cfg_tab[sel][btcc_pkg::CFG_VALID_BIT] = 1'b0;
                    a.ok = 1'b1;
                end
                btcc_pkg::OP_FREE_ALL:
                begin
                    foreach (cfg_tab[i])
                        cfg_tab[i] = '0;
                    a.ok = 1'b1;
                end
                btcc_pkg::OP_CHECK:
                begin
                    a.ok = 1'b1;
                    a.covered = reaches(lo, hi, pb);
                end
                btcc_pkg::OP_READ:
                begin
                    a.ok = 1'b1;
                    a.slot_cfg = cfg_tab[sel];
                end
                default: ;
            endcase
            pending.push_back(a);
        endfunction

        function void check_result(logic r_ok, logic [3:0] r_slot, logic r_cov,
                                   logic [3:0] r_cfg);
            answer_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result with no request outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (r_ok !== e.ok)
            begin
                $error("ok: expected %0d, got %0d", e.ok, r_ok);
                errors++;
            end
            if (r_slot !== e.slot_out)
            begin
                $error("slot_out: expected %0d, got %0d", e.slot_out, r_slot);
                errors++;
            end
            if (r_cov !== e.covered)
            begin
                $error("covered: expected %0d, got %0d", e.covered, r_cov);
                errors++;
            end
            if (r_cfg !== e.slot_cfg)
            begin
                $error("slot_cfg: expected %0h, got %0h", e.slot_cfg, r_cfg);
                errors++;
            end
        endfunction
    endclass

    logic        clk, rst_n, start, busy, done, ok, covered;
    logic [2:0]  kind;
    logic [3:0]  perm_bits, slot_sel, slot_out, slot_cfg;
    logic [63:0] range_lo, range_hi;
    int          idle_pct;
    bound_scoreboard sb;

    bound_table_coverage_checker_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .perm_bits(perm_bits), .range_lo(range_lo), .range_hi(range_hi),
        .slot_sel(slot_sel), .done(done), .ok(ok), .slot_out(slot_out),
        .covered(covered), .slot_cfg(slot_cfg)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(ok, slot_out, covered, slot_cfg);
    end

    // Drives one request and holds it until the block takes it.
    task automatic send_request(logic [2:0] k, logic [3:0] pb, logic [63:0] lo,
                                logic [63:0] hi, logic [3:0] sel);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        kind <= k;
        perm_bits <= pb;
        range_lo <= lo;
        range_hi <= hi;
        slot_sel <= sel;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(k, pb, lo, hi, sel);
    endtask

    function automatic logic [63:0] rand_addr();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: return v;
            1: return v & 64'hFF;
            2: return ADDR_MAX - (v & 64'hF);
            default: return 64'h1000 + (v & 64'h3FF);
        endcase
    endfunction

    // Mostly tidy chains over a small window so that checks see real coverage.
    task automatic random_request();
        logic [63:0] lo, hi;
        int r;
        r = $urandom_range(99);
        lo = rand_addr();
        hi = ($urandom_range(1)) ? lo + 64'($urandom_range(300)) : rand_addr();
        if (r < 30)
            send_request(btcc_pkg::OP_ALLOC, 4'($urandom), lo, hi, 4'($urandom));
        else if (r < 45)
            send_request(btcc_pkg::OP_FREE, 4'($urandom), lo, hi, 4'($urandom));
        else if (r < 48)
            send_request(btcc_pkg::OP_FREE_ALL, 4'($urandom), lo, hi, 4'($urandom));
        else if (r < 80)
            send_request(btcc_pkg::OP_CHECK, 4'($urandom), lo, hi, 4'($urandom));
        else if (r < 95)
            send_request(btcc_pkg::OP_READ, 4'($urandom), lo, hi, 4'($urandom));
        else
            send_request(3'($urandom_range(7, 5)), 4'($urandom), lo, hi, 4'($urandom));
    endtask

    initial
    begin
        sb = new();
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = btcc_pkg::OP_READ;
        perm_bits = '0;
        range_lo = '0;
        range_hi = '0;
        slot_sel = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(btcc_pkg::OP_READ, 4'h0, 64'd0, 64'd0, 4'd0);
        send_request(btcc_pkg::OP_ALLOC, 4'hF, 64'h0, 64'h10, 4'd0);
        send_request(btcc_pkg::OP_ALLOC, 4'h1, 64'h13, 64'h27, 4'd0);
        send_request(btcc_pkg::OP_ALLOC, 4'h2, 64'h2F, ADDR_MAX - 64'd3, 4'd0);
        send_request(btcc_pkg::OP_CHECK, 4'h1, 64'h0, 64'h28, 4'd0);
        send_request(btcc_pkg::OP_CHECK, 4'h8, 64'h0, 64'h8, 4'd0);
        send_request(btcc_pkg::OP_CHECK, 4'h7, 64'h0, ADDR_MAX, 4'd0);
        send_request(btcc_pkg::OP_CHECK, 4'h4, 64'h5, 64'h5, 4'd0);
        send_request(btcc_pkg::OP_READ, 4'h0, 64'd0, 64'd0, 4'd2);
        send_request(btcc_pkg::OP_FREE, 4'h0, 64'd0, 64'd0, 4'd1);
        send_request(btcc_pkg::OP_READ, 4'h0, 64'd0, 64'd0, 4'd1);
        send_request(btcc_pkg::OP_CHECK, 4'h7, 64'h0, 64'h40, 4'd0);
        for (int i = 0; i < 15; i++)
            send_request(btcc_pkg::OP_ALLOC, 4'(i), ADDR_MAX, ADDR_MAX, 4'd0);
        send_request(btcc_pkg::OP_READ, 4'h0, 64'd0, 64'd0, 4'd15);
        send_request(btcc_pkg::OP_CHECK, 4'h1, ADDR_MAX, ADDR_MAX, 4'd0);
        send_request(3'd5, 4'h0, 64'd0, 64'd0, 4'd0);
        send_request(3'd7, 4'hF, ADDR_MAX, ADDR_MAX, 4'hF);
        send_request(btcc_pkg::OP_FREE_ALL, 4'h0, 64'd0, 64'd0, 4'd0);

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 0) ? 0 : (phase == 2) ? 23 : 74;
            for (int n = 0; n < 100; n++)
                random_request();
        end

        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
